[rtl/vrot_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the vector rotation core.
package vrot_pkg;

  localparam int ATAN_COUNT = 24;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int PRE_STAGES = 11;

  // 1/K of the CORDIC gain in Q2.30
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  // eighth of a turn in 32-bit turn units, used to pick the nearest quadrant
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic signed [33:0] cw_t;
  typedef logic signed [39:0] par_t;
  typedef logic signed [31:0] w32_t;

  // CORDIC cell data
  typedef struct packed {
    cw_t        x;
    cw_t        y;
    cw_t        z;
    logic [1:0] quad;
  } cordic_t;

  // square root cell data
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  // divider cell data
  typedef struct packed {
    logic [61:0] rem;
    logic [32:0] den;
    logic [30:0] quo;
  } div_t;

  // per-item data that rides alongside the long cell chains
  typedef struct packed {
    par_t [2:0] p;
    w32_t [2:0] rs;
    w32_t [2:0] cn;
    logic [3:0] s;
    logic       zero;
    logic [32:0] rad;
  } side_t;

  // one finished result
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        on_axis;
  } res_t;

  // arctangent of 2^-idx in 32-bit turn units
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] val;
    unique case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458907;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/vrot_cordic_cell.sv]
// One rotation-mode CORDIC step with its output register.
module vrot_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  vrot_pkg::cordic_t d,
  output vrot_pkg::cordic_t q
);

  vrot_pkg::cw_t     dx;
  vrot_pkg::cw_t     dy;
  vrot_pkg::cw_t     da;
  vrot_pkg::cordic_t nx;

  // rotate toward zero residual angle, shifts floor
  always_comb begin
    dx      = $signed(d.y) >>> STEP;
    dy      = $signed(d.x) >>> STEP;
    da      = 34'(vrot_pkg::atan_turn(STEP));
    nx.quad = d.quad;
    if (!d.z[33]) begin
      nx.x = $signed(d.x) - dx;
      nx.y = $signed(d.y) + dy;
      nx.z = $signed(d.z) - da;
    end else begin
      nx.x = $signed(d.x) + dx;
      nx.y = $signed(d.y) - dy;
      nx.z = $signed(d.z) + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end

endmodule

[rtl/vrot_sqrt_cell.sv]
// One digit step of the 64-bit integer square root with its output register.
module vrot_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  vrot_pkg::sqrt_t d,
  output vrot_pkg::sqrt_t q
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0]     trial;
  vrot_pkg::sqrt_t nx;

  // take the digit when the remainder covers root plus bit
  always_comb begin
    trial = d.root + BIT;
    if (d.rem >= trial) begin
      nx.rem  = d.rem - trial;
      nx.root = (d.root >> 1) + BIT;
    end else begin
      nx.rem  = d.rem;
      nx.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end

endmodule

[rtl/vrot_div_cell.sv]
// One quotient bit of a restoring unsigned divider with its output register.
module vrot_div_cell #(
  parameter int BITPOS = 0
) (
  input  logic           clk,
  input  logic           en,
  input  vrot_pkg::div_t d,
  output vrot_pkg::div_t q
);

  logic [63:0]    shifted;
  logic [63:0]    rem_w;
  vrot_pkg::div_t nx;

  // subtract the shifted divisor when it fits and set the quotient bit
  always_comb begin
    shifted = 64'(d.den) << BITPOS;
    rem_w   = {2'b00, d.rem};
    nx      = d;
    if (rem_w >= shifted) begin
      nx.rem         = 62'(rem_w - shifted);
      nx.quo[BITPOS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end

endmodule

[rtl/vector_rotate_about_axis_core.sv]
// Pipelined rotation of a 3D vector about a unit axis (Rodrigues form).
//
//   channel | signals                                         | transfer when
//   in      | in_valid, in_ready, vec_*, axis_*, angle         | in_valid && in_ready
//   out     | out_valid, out_ready, out_*, on_axis             | out_valid && out_ready
//
// One item per clock sustained while the output buffer is not full.
// The pipeline depth is dominated by the two cell chains: 32 square-root cells and 31 divider
// cells in series, with the CORDIC chain running alongside.
// Reset (rst, synchronous) empties the pipeline and the output buffer.
// A two-entry output buffer holds results; the whole pipeline halts only when
// both entries are full, so in_ready is a register output.
module vector_rotate_about_axis_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic        [15:0] angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               on_axis
);

  localparam int NC = (CORDIC_STAGES < vrot_pkg::ATAN_COUNT) ?
                      CORDIC_STAGES : vrot_pkg::ATAN_COUNT;
  localparam int NSQ = vrot_pkg::SQRT_STEPS;
  localparam int NDV = vrot_pkg::DIV_STEPS;
  localparam int TRIG_AT  = vrot_pkg::PRE_STAGES + NSQ + NDV + 1;
  localparam int TRIG_DLY = TRIG_AT - NC;

  logic en;

  // ---------------- input views ----------------
  logic signed [31:0] vin [3];
  logic signed [15:0] ain [3];
  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;
  assign ain[0] = axis_x;
  assign ain[1] = axis_y;
  assign ain[2] = axis_z;

  // ---------------- stage registers ----------------
  logic va, vb, vc, vd, ve, vf, vg, vh, vi, vj, vk, vl, vm, vn, vo, vp, vq;

  logic signed [31:0] a_v [3];
  logic signed [15:0] a_ax [3];
  logic signed [47:0] a_pr [3];

  logic signed [31:0] b_v [3];
  logic signed [15:0] b_ax [3];
  logic signed [37:0] b_d;

  logic signed [31:0] c_v [3];
  logic signed [15:0] c_ax [3];
  logic signed [53:0] c_ad [3];

  logic signed [15:0] d_ax [3];
  logic signed [39:0] d_p [3];
  logic signed [40:0] d_r [3];

  logic signed [15:0] e_ax [3];
  vrot_pkg::side_t    e_side;

  logic        [63:0] f_sq [3];
  logic signed [47:0] f_cp [6];
  vrot_pkg::side_t    f_side;

  logic        [63:0] g_sumr;
  logic signed [48:0] g_c [3];
  vrot_pkg::side_t    g_side;

  logic        [63:0] h_sumr;
  logic signed [48:0] h_c [3];
  logic        [5:0]  h_bl;
  vrot_pkg::side_t    h_side;

  logic        [63:0] i_sumr;
  vrot_pkg::side_t    i_side;

  logic        [63:0] j_sumr;
  logic        [63:0] j_cq [3];
  vrot_pkg::side_t    j_side;

  logic        [63:0] k_sumr;
  logic        [63:0] k_sumc;
  vrot_pkg::side_t    k_side;

  logic signed [31:0] l_yh [3];
  vrot_pkg::side_t    l_side;

  logic signed [65:0] m_ys [3];
  logic signed [65:0] m_rc [3];
  vrot_pkg::side_t    m_side;

  logic signed [35:0] n_term [3];
  logic signed [65:0] n_rc [3];
  vrot_pkg::side_t    n_side;

  logic signed [69:0] o_rt [3];
  logic signed [65:0] o_rc [3];
  vrot_pkg::side_t    o_side;

  logic signed [71:0] p_tot [3];
  vrot_pkg::side_t    p_side;

  logic signed [71:0] q_y [3];
  vrot_pkg::side_t    q_side;

  // ---------------- combinational helpers ----------------
  logic signed [49:0] dsum;
  logic        [40:0] rmag [3];
  logic        [40:0] rmax;
  logic        [3:0]  s_n;
  logic signed [31:0] rs_n [3];
  logic        [48:0] cmag [3];
  logic        [48:0] cmax;
  logic        [5:0]  bl_n;
  logic signed [31:0] cn_n [3];
  logic        [4:0]  rsh;
  logic signed [71:0] rnd;

  always_comb begin
    dsum = 50'(a_pr[0]) + 50'(a_pr[1]) + 50'(a_pr[2]);

    // scale the perpendicular part below 2^31
    for (int i = 0; i < 3; i++) begin
      rmag[i] = d_r[i][40] ? 41'(-d_r[i]) : 41'(d_r[i]);
    end
    rmax = rmag[0];
    if (rmag[1] > rmax) rmax = rmag[1];
    if (rmag[2] > rmax) rmax = rmag[2];
    s_n = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (rmax[31 + k]) s_n = 4'(k + 1);
    end
    for (int i = 0; i < 3; i++) begin
      rs_n[i] = 32'(d_r[i] >>> s_n);
    end

    // bit length of the largest cross product component
    for (int i = 0; i < 3; i++) begin
      cmag[i] = g_c[i][48] ? 49'(-g_c[i]) : 49'(g_c[i]);
    end
    cmax = cmag[0];
    if (cmag[1] > cmax) cmax = cmag[1];
    if (cmag[2] > cmax) cmax = cmag[2];
    bl_n = 6'd0;
    for (int k = 0; k < 49; k++) begin
      if (cmax[k]) bl_n = 6'(k + 1);
    end

    // bring the cross product into [2^30, 2^31)
    for (int i = 0; i < 3; i++) begin
      if (h_bl > 6'd31) begin
        cn_n[i] = 32'(h_c[i] >>> (h_bl - 6'd31));
      end else begin
        cn_n[i] = 32'(h_c[i] <<< (6'd31 - h_bl));
      end
    end

    rsh = 5'd30 - 5'(p_side.s);
    rnd = 72'sd1 <<< (rsh - 5'd1);
  end

  // ---------------- front stages: projection, scaling, cross product ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_v[i]  <= vin[i];
        a_ax[i] <= ain[i];
        a_pr[i] <= 48'(vin[i]) * 48'(ain[i]);
      end

      b_v  <= a_v;
      b_ax <= a_ax;
      b_d  <= 38'((dsum + 50'sd8192) >>> 14);

      c_v  <= b_v;
      c_ax <= b_ax;
      for (int i = 0; i < 3; i++) begin
        c_ad[i] <= 54'(b_ax[i]) * 54'(b_d);
      end

      d_ax <= c_ax;
      for (int i = 0; i < 3; i++) begin
        d_p[i] <= 40'((c_ad[i] + 54'sd8192) >>> 14);
        d_r[i] <= 41'(c_v[i]) - 41'(40'((c_ad[i] + 54'sd8192) >>> 14));
      end

      e_ax <= d_ax;
      for (int i = 0; i < 3; i++) begin
        e_side.p[i]  <= d_p[i];
        e_side.rs[i] <= rs_n[i];
        e_side.cn[i] <= 32'sd0;
      end
      e_side.s    <= s_n;
      e_side.zero <= (d_r[0] == 41'sd0) && (d_r[1] == 41'sd0) && (d_r[2] == 41'sd0);
      e_side.rad  <= 33'd0;

      for (int i = 0; i < 3; i++) begin
        f_sq[i] <= 64'($signed(e_side.rs[i]) * $signed(e_side.rs[i]));
      end
      f_cp[0] <= 48'(e_ax[1]) * 48'($signed(e_side.rs[2]));
      f_cp[1] <= 48'(e_ax[2]) * 48'($signed(e_side.rs[1]));
      f_cp[2] <= 48'(e_ax[2]) * 48'($signed(e_side.rs[0]));
      f_cp[3] <= 48'(e_ax[0]) * 48'($signed(e_side.rs[2]));
      f_cp[4] <= 48'(e_ax[0]) * 48'($signed(e_side.rs[1]));
      f_cp[5] <= 48'(e_ax[1]) * 48'($signed(e_side.rs[0]));
      f_side  <= e_side;

      g_sumr <= f_sq[0] + f_sq[1] + f_sq[2];
      for (int i = 0; i < 3; i++) begin
        g_c[i] <= 49'(f_cp[2 * i]) - 49'(f_cp[2 * i + 1]);
      end
      g_side <= f_side;

      h_sumr <= g_sumr;
      h_c    <= g_c;
      h_bl   <= bl_n;
      h_side <= g_side;

      i_sumr      <= h_sumr;
      i_side.p    <= h_side.p;
      i_side.rs   <= h_side.rs;
      i_side.s    <= h_side.s;
      i_side.zero <= h_side.zero;
      i_side.rad  <= h_side.rad;
      for (int i = 0; i < 3; i++) begin
        i_side.cn[i] <= cn_n[i];
      end

      j_sumr <= i_sumr;
      for (int i = 0; i < 3; i++) begin
        j_cq[i] <= 64'($signed(i_side.cn[i]) * $signed(i_side.cn[i]));
      end
      j_side <= i_side;

      k_sumr <= j_sumr;
      k_sumc <= j_cq[0] + j_cq[1] + j_cq[2];
      k_side <= j_side;
    end
  end

  // ---------------- square root chain: radius and cross product length ----------------
  vrot_pkg::sqrt_t sq_d [NSQ + 1][2];
  vrot_pkg::side_t sq_side [NSQ + 1];
  logic            sq_vld [NSQ + 1];

  assign sq_d[0][0] = '{rem: k_sumr, root: 64'd0};
  assign sq_d[0][1] = '{rem: k_sumc, root: 64'd0};
  assign sq_side[0] = k_side;
  assign sq_vld[0]  = vk;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    for (genvar l = 0; l < 2; l++) begin : g_lane
      vrot_sqrt_cell #(.STEP(g)) u_cell (
        .clk (clk),
        .en  (en),
        .d   (sq_d[g][l]),
        .q   (sq_d[g + 1][l])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[g + 1] <= sq_side[g];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[g + 1] <= 1'b0;
      end else if (en) begin
        sq_vld[g + 1] <= sq_vld[g];
      end
    end
  end

  // ---------------- divider chain: unit vector yhat ----------------
  vrot_pkg::div_t  dv_d [NDV + 1][3];
  vrot_pkg::side_t dv_side [NDV + 1];
  logic            dv_vld [NDV + 1];
  logic [32:0]     len;
  logic [31:0]     cn_mag [3];

  always_comb begin
    len = (sq_d[NSQ][1].root == 64'd0) ? 33'd1 : 33'(sq_d[NSQ][1].root);
    dv_side[0]     = sq_side[NSQ];
    dv_side[0].rad = 33'(sq_d[NSQ][0].root);
    for (int i = 0; i < 3; i++) begin
      cn_mag[i] = sq_side[NSQ].cn[i][31] ? 32'(-$signed(sq_side[NSQ].cn[i]))
                                         : 32'(sq_side[NSQ].cn[i]);
      dv_d[0][i] = '{rem: {cn_mag[i], 30'd0}, den: len, quo: 31'd0};
    end
  end
  assign dv_vld[0] = sq_vld[NSQ];

  for (genvar g = 0; g < NDV; g++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      vrot_div_cell #(.BITPOS(NDV - 1 - g)) u_cell (
        .clk (clk),
        .en  (en),
        .d   (dv_d[g][l]),
        .q   (dv_d[g + 1][l])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[g + 1] <= dv_side[g];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[g + 1] <= 1'b0;
      end else if (en) begin
        dv_vld[g + 1] <= dv_vld[g];
      end
    end
  end

  // ---------------- CORDIC chain and alignment delay ----------------
  vrot_pkg::cordic_t cd [NC + 1];
  logic [31:0]       a32;
  logic [31:0]       zres;
  logic [1:0]        quad0;
  vrot_pkg::cw_t     cs_n;
  vrot_pkg::cw_t     sn_n;
  vrot_pkg::cw_t     tr_cs [TRIG_DLY + 1];
  vrot_pkg::cw_t     tr_sn [TRIG_DLY + 1];

  always_comb begin
    a32      = {angle, 16'd0};
    quad0    = 2'((a32 + vrot_pkg::EIGHTH_TURN) >> 30);
    zres     = a32 - {quad0, 30'd0};
    cd[0].x  = vrot_pkg::CORDIC_INV_GAIN;
    cd[0].y  = 34'sd0;
    cd[0].z  = 34'($signed(zres));
    cd[0].quad = quad0;
  end

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    vrot_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (cd[g]),
      .q   (cd[g + 1])
    );
  end

  // apply the quadrant by swap and negate
  always_comb begin
    unique case (cd[NC].quad)
      vrot_pkg::QUAD_0: begin cs_n = cd[NC].x;  sn_n = cd[NC].y;  end
      vrot_pkg::QUAD_1: begin cs_n = -cd[NC].y; sn_n = cd[NC].x;  end
      vrot_pkg::QUAD_2: begin cs_n = -cd[NC].x; sn_n = -cd[NC].y; end
      vrot_pkg::QUAD_3: begin cs_n = cd[NC].y;  sn_n = -cd[NC].x; end
    endcase
  end
  assign tr_cs[0] = cs_n;
  assign tr_sn[0] = sn_n;

  for (genvar g = 0; g < TRIG_DLY; g++) begin : g_trig_dly
    always_ff @(posedge clk) begin
      if (en) begin
        tr_cs[g + 1] <= tr_cs[g];
        tr_sn[g + 1] <= tr_sn[g];
      end
    end
  end

  // ---------------- back stages: combine and round ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l_yh[i] <= dv_side[NDV].cn[i][31] ? -$signed({1'b0, dv_d[NDV][i].quo})
                                          : $signed({1'b0, dv_d[NDV][i].quo});
      end
      l_side <= dv_side[NDV];

      for (int i = 0; i < 3; i++) begin
        m_ys[i] <= 66'(l_yh[i]) * 66'(tr_sn[TRIG_DLY]);
        m_rc[i] <= 66'($signed(l_side.rs[i])) * 66'(tr_cs[TRIG_DLY]);
      end
      m_side <= l_side;

      for (int i = 0; i < 3; i++) begin
        n_term[i] <= 36'((m_ys[i] + 66'sd536870912) >>> 30);
      end
      n_rc   <= m_rc;
      n_side <= m_side;

      for (int i = 0; i < 3; i++) begin
        o_rt[i] <= 70'($signed({1'b0, n_side.rad})) * 70'(n_term[i]);
      end
      o_rc   <= n_rc;
      o_side <= n_side;

      for (int i = 0; i < 3; i++) begin
        p_tot[i] <= 72'(o_rc[i]) + 72'(o_rt[i]);
      end
      p_side <= o_side;

      for (int i = 0; i < 3; i++) begin
        q_y[i] <= (p_tot[i] + rnd) >>> rsh;
      end
      q_side <= p_side;
    end
  end

  // ---------------- stage valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0; vf <= 1'b0;
      vg <= 1'b0; vh <= 1'b0; vi <= 1'b0; vj <= 1'b0; vk <= 1'b0; vl <= 1'b0;
      vm <= 1'b0; vn <= 1'b0; vo <= 1'b0; vp <= 1'b0; vq <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va; vc <= vb; vd <= vc; ve <= vd; vf <= ve;
      vg <= vf; vh <= vg; vi <= vh; vj <= vi; vk <= vj;
      vl <= dv_vld[NDV];
      vm <= vl; vn <= vm; vo <= vn; vp <= vo; vq <= vp;
    end
  end

  // ---------------- final add, saturation, on-axis bypass ----------------
  vrot_pkg::res_t res_n;
  logic signed [72:0] fsum [3];
  logic        [31:0] fout [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i] = 73'(q_y[i]) + 73'($signed(q_side.p[i]));
      if (q_side.zero) begin
        fout[i] = 32'(q_side.p[i]);
      end else if (fsum[i] > 73'sd2147483647) begin
        fout[i] = 32'h7FFF_FFFF;
      end else if (fsum[i] < -73'sd2147483648) begin
        fout[i] = 32'h8000_0000;
      end else begin
        fout[i] = 32'(fsum[i]);
      end
    end
    res_n.x       = fout[0];
    res_n.y       = fout[1];
    res_n.z       = fout[2];
    res_n.on_axis = q_side.zero;
  end

  // ---------------- output register and skid entry ----------------
  vrot_pkg::res_t ob;
  vrot_pkg::res_t sk;
  logic           ob_v;
  logic           sk_v;
  logic           push;
  logic           pop;

  assign en   = !sk_v;
  assign push = en && vq;
  assign pop  = ob_v && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_v <= 1'b0;
      sk_v <= 1'b0;
    end else begin
      priority if (pop && sk_v) begin
        sk_v <= 1'b0;
      end else if (pop || !ob_v) begin
        ob_v <= push;
      end else if (push) begin
        sk_v <= 1'b1;
      end
    end
  end

  // move payload along with the valid bits
  always_ff @(posedge clk) begin
    priority if (pop && sk_v) begin
      ob <= sk;
    end else if ((pop || !ob_v) && push) begin
      ob <= res_n;
    end else if (push) begin
      sk <= res_n;
    end
  end

  assign in_ready  = en;
  assign out_valid = ob_v;
  assign out_x     = ob.x;
  assign out_y     = ob.y;
  assign out_z     = ob.z;
  assign on_axis   = ob.on_axis;

endmodule

[rtl/vrot_checker.sv]
// Port-level checks for the vector rotation core, bound to the top level.
module vrot_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        on_axis
);

  // hold a result that was not taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                && $stable(out_z) && $stable(on_axis))
    else $error("result changed before transfer");

  // stall only while a result waits at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // the buffer fills only when the consumer held off
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not empty after reset");

endmodule

bind vector_rotate_about_axis_core vrot_checker u_vrot_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for the vector rotation core: random and directed rotations.
`timescale 1ns / 1ps

module tb;

  localparam int STAGES = 16;
  localparam int LATENCY = 80;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [15:0] ang;
  } rot_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic on_ax;
  } rot_res_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, on_axis;
  logic signed [31:0] vec_x, vec_y, vec_z, out_x, out_y, out_z;
  logic signed [15:0] axis_x, axis_y, axis_z;
  logic [15:0] angle;

  rot_req_t pending_reqs[$];
  rot_res_t expected_rots[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_on_axis = 0;
  bit stim_done = 0;
  bit hold_sender = 0;
  int stall_long = 0;

  vector_rotate_about_axis_core #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .on_axis(on_axis)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // floor shift right
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rshr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // CORDIC sine and cosine in Q2.30
  function automatic void trig_q30(logic [15:0] ang, output longint c, output longint sn);
    logic [31:0] a32, zr;
    logic [1:0] q;
    longint z, x, y, dx, dy;
    a32 = {ang, 16'd0};
    q = 2'((a32 + vrot_pkg::EIGHTH_TURN) >> 30);
    zr = a32 - ({30'd0, q} << 30);
    z = longint'(signed'(zr));
    x = vrot_pkg::CORDIC_INV_GAIN;
    y = 0;
    for (int i = 0; i < STAGES && i < vrot_pkg::ATAN_COUNT; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(vrot_pkg::atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(vrot_pkg::atan_turn(i));
      end
    end
    case (q)
      vrot_pkg::QUAD_0: begin c = x; sn = y; end
      vrot_pkg::QUAD_1: begin c = -y; sn = x; end
      vrot_pkg::QUAD_2: begin c = -x; sn = -y; end
      default: begin c = y; sn = -x; end
    endcase
  endfunction

  function automatic rot_res_t rotate_about_axis(rot_req_t q);
    longint v[3], a[3], p[3], r[3], rs[3], cr[3], yh[3];
    longint d, rad, cs, sn, tot, len;
    longint unsigned m, sum;
    int s, sh, up;
    rot_res_t res;
    s = 0; sh = 0; up = 0;
    v[0] = q.vx; v[1] = q.vy; v[2] = q.vz;
    a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
    d = rshr(v[0] * a[0] + v[1] * a[1] + v[2] * a[2], 14);
    for (int i = 0; i < 3; i++) begin
      p[i] = rshr(a[i] * d, 14);
      r[i] = v[i] - p[i];
    end
    if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
      res.x = q.vx; res.y = q.vy; res.z = q.vz; res.on_ax = 1'b1;
      return res;
    end
    m = mag64(r[0]);
    if (mag64(r[1]) > m) m = mag64(r[1]);
    if (mag64(r[2]) > m) m = mag64(r[2]);
    while (m >= 64'd2147483648) begin m >>= 1; s++; end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      rs[i] = fshr(r[i], s);
      sum += rs[i] * rs[i];
    end
    rad = root64(sum);
    cr[0] = a[1] * rs[2] - a[2] * rs[1];
    cr[1] = a[2] * rs[0] - a[0] * rs[2];
    cr[2] = a[0] * rs[1] - a[1] * rs[0];
    m = mag64(cr[0]);
    if (mag64(cr[1]) > m) m = mag64(cr[1]);
    if (mag64(cr[2]) > m) m = mag64(cr[2]);
    if (m == 0) begin
      yh[0] = 0; yh[1] = 0; yh[2] = 0;
    end else begin
      while (m >= 64'd2147483648) begin m >>= 1; sh++; end
      while (m < (64'd1 << 30)) begin m <<= 1; up++; end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        cr[i] = fshr(cr[i], sh) * (64'sd1 <<< up);
        sum += cr[i] * cr[i];
      end
      len = root64(sum);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) yh[i] = (cr[i] * (64'sd1 <<< 30)) / len;
    end
    trig_q30(q.ang, cs, sn);
    for (int i = 0; i < 3; i++) begin
      tot = rs[i] * cs + rad * rshr(yh[i] * sn, 30);
      tot = rshr(tot, 30 - s);
      tot = clamp32(p[i] + tot);
      if (i == 0) res.x = tot[31:0];
      else if (i == 1) res.y = tot[31:0];
      else res.z = tot[31:0];
    end
    res.on_ax = 1'b0;
    return res;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [15:0] rand_axis();
    logic signed [15:0] a;
    a = 16'($urandom_range(0, 32768)) - 16'sd16384;
    return a;
  endfunction

  // random item: unit axes in half of the cases, with mixed vector magnitudes
  function automatic rot_req_t rand_req();
    rot_req_t q;
    int k, pick;
    k = $urandom_range(0, 9);
    q.vx = $urandom; q.vy = $urandom; q.vz = $urandom;
    if (k < 4) begin
      q.vx = $signed(q.vx) >>> $urandom_range(0, 24);
      q.vy = $signed(q.vy) >>> $urandom_range(0, 24);
      q.vz = $signed(q.vz) >>> $urandom_range(0, 24);
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      q.ax = 0; q.ay = 0; q.az = 0;
      case ($urandom_range(0, 2))
        0: q.ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        1: q.ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        default: q.az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      endcase
      // vector along the axis now and then
      if ($urandom_range(0, 4) == 0) begin
        if (q.ax != 0) begin q.vy = 0; q.vz = 0; end
        else if (q.ay != 0) begin q.vx = 0; q.vz = 0; end
        else begin q.vx = 0; q.vy = 0; end
      end
    end else if (pick < 9) begin
      q.ax = rand_axis(); q.ay = rand_axis(); q.az = rand_axis();
    end else begin
      q.ax = 16'($urandom); q.ay = 16'($urandom); q.az = 16'($urandom);
    end
    q.ang = 16'($urandom);
    return q;
  endfunction

  function automatic rot_req_t mk(int vx, int vy, int vz, int ax, int ay, int az, int ang);
    rot_req_t q;
    q.vx = vx; q.vy = vy; q.vz = vz;
    q.ax = 16'(ax); q.ay = 16'(ay); q.az = 16'(az); q.ang = 16'(ang);
    return q;
  endfunction

  // driver: offer the next pending item, hold it until transfer
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rots.push_back(rotate_about_axis({vec_x, vec_y, vec_z,
                                                   axis_x, axis_y, axis_z, angle}));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!hold_sender && pending_reqs.size() > 0) begin
          rot_req_t q;
          q = pending_reqs.pop_front();
          vec_x <= q.vx; vec_y <= q.vy; vec_z <= q.vz;
          axis_x <= q.ax; axis_y <= q.ay; axis_z <= q.az; angle <= q.ang;
          in_valid <= 1'b1;
          in_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_got++;
        if (expected_rots.size() == 0) begin
          $error("unexpected result x=%0d y=%0d z=%0d", out_x, out_y, out_z);
          errors++;
        end else begin
          rot_res_t e;
          e = expected_rots.pop_front();
          if (on_axis) n_on_axis++;
          if (out_x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x); errors++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y); errors++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %0d actual %0d", e.z, out_z); errors++;
          end
          if (on_axis !== e.on_ax) begin
            $error("on_axis expected %0b actual %0b", e.on_ax, on_axis); errors++;
          end
        end
      end
      if (stall_long > 0) begin
        stall_long--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (stim_done || $urandom_range(0, 2) != 0) out_gap = 0;
        else out_gap = gap_len();
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst = 1'b1;
    in_valid = 1'b0; out_ready = 1'b0;
    vec_x = 0; vec_y = 0; vec_z = 0;
    axis_x = 0; axis_y = 0; axis_z = 0; angle = 0;
    // directed: extremes, on-axis, zero and odd axes, quadrant edges
    pending_reqs.push_back(mk(0, 0, 0, 16384, 0, 0, 0));
    pending_reqs.push_back(mk(65536, 0, 0, 16384, 0, 0, 16384));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 16384, 16384));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 16384, 32768));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 16384, 49152));
    pending_reqs.push_back(mk(65536, 65536, 0, 0, 0, -16384, 8192));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 16384, 65535));
    pending_reqs.push_back(mk(65536, 0, 0, 0, 0, 16384, 24576));
    pending_reqs.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 16384, 8192));
    pending_reqs.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 0, 16384, 0, 40000));
    pending_reqs.push_back(mk(32'h80000000, 32'h7fffffff, 0, -16384, 0, 0, 32768));
    pending_reqs.push_back(mk(32'h7fffffff, 32'h80000000, 12345, 16384, 16384, 16384, 1234));
    pending_reqs.push_back(mk(100000, -50000, 70000, 0, 0, 0, 16384));
    pending_reqs.push_back(mk(1, 1, 1, 9459, 9459, 9459, 30000));
    pending_reqs.push_back(mk(5, -7, 3, -32768, 32767, -1, 65535));
    pending_reqs.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff,
                              -32768, -32768, 32767, 12000));
    pending_reqs.push_back(mk(1, 0, 0, 0, 16384, 0, 1));
    pending_reqs.push_back(mk(-200000, 300000, -400000, 11585, 11585, 0, 20000));
    pending_reqs.push_back(mk(0, 0, 123456, 0, 0, -16384, 777));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // wait for the last directed item to transfer
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid);
    // sender pause until the pipeline drains
    hold_sender = 1;
    wait (expected_rots.size() == 0);
    hold_sender = 0;
    for (int i = 0; i < 1330; i++) pending_reqs.push_back(rand_req());
    // long receiver hold-off while the sender keeps offering
    wait (n_sent > 300);
    @(posedge clk);
    stall_long = 600;
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid);
    stim_done = 1;
    wait (expected_rots.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Covered %0d rotations (%0d on-axis), with random gaps and a long output stall.",
             n_got, n_on_axis);
    if (errors == 0 && expected_rots.size() == 0)
      $display("vector_rotate_about_axis_core test passed");
    else
      $display("vector_rotate_about_axis_core test failed");
    $finish;
  end

  // run limit
  initial begin
    #(8 * 200000);
    $display("vector_rotate_about_axis_core test failed");
    $finish;
  end

endmodule
